// ===== rtl/gbi_pkg.sv =====
package gbi_pkg;

    localparam int DEF_MAX_COLS  = 128;
    localparam int DEF_MAX_ROWS  = 128;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_NODATA  = 2'd2;

    localparam logic [2:0] REG_X_ORIGIN = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] REG_X_SCALE  = 3'd2;
    localparam logic [2:0] REG_Y_SCALE  = 3'd3;
    localparam logic [2:0] REG_COLS     = 3'd4;
    localparam logic [2:0] REG_ROWS     = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // per-query control that travels from the front to the back
    typedef struct packed {
        logic       outside;
        logic       col_odd;
        logic       row_odd;
    } gbi_ctrl_t;

endpackage

// ===== rtl/gbi_ram.sv =====
module gbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gbi_front.sv =====
module gbi_front
    import gbi_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = $clog2(MAX_ROWS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [31:0]   query_x,
    input  logic signed [31:0]   query_y,
    input  logic signed [31:0]   x_origin,
    input  logic signed [31:0]   y_origin,
    input  logic [31:0]          x_scale,
    input  logic [31:0]          y_scale,
    input  logic [7:0]           cols_in_use,
    input  logic [7:0]           rows_in_use,
    input  logic                 depth_mode,
    output logic                 q_valid,
    output gbi_ctrl_t            q_ctrl,
    output logic [CW-1:0]        q_col,
    output logic [RW-1:0]        q_row,
    output logic [FRAC_BITS-1:0] q_fx,
    output logic [FRAC_BITS-1:0] q_fy
);

    localparam int PW = 65;
    localparam int LW = 11;

    // stage 1: distance
    logic               s1_valid_reg;
    logic signed [33:0] dx_reg, dy_reg;
    logic               bad_cnt_reg;
    logic [LW-1:0]      cols_reg, rows_reg;
    logic [31:0]        xs_reg, ys_reg;
    logic signed [33:0] dx_next, dy_next;
    logic [LW-1:0]      cols_c, rows_c;

    // stage 2: product
    logic               s2_valid_reg;
    logic [PW-1:0]      px_reg, py_reg;
    logic               negx_reg, negy_reg, bad2_reg;
    logic [LW-1:0]      cols2_reg, rows2_reg;
    logic [32:0]        mx, my;

    logic [PW-1:0]      offx, offy;
    logic [PW-1:0]      wx, wy;
    logic               outx, outy;

    always_comb
    begin
        cols_c = (LW'(cols_in_use) > LW'(MAX_COLS)) ? LW'(MAX_COLS) : LW'(cols_in_use);
        rows_c = (LW'(rows_in_use) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(rows_in_use);
        if (depth_mode)
        begin
            dx_next = 34'(query_x);
            dy_next = -34'(query_y);
        end
        else
        begin
            dx_next = 34'(query_x) - 34'(x_origin);
            dy_next = 34'(query_y) - 34'(y_origin);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            q_valid      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            q_valid      <= s2_valid_reg;
        end
    end

    always_comb
    begin
        mx = dx_reg[33] ? 33'(-dx_reg) : 33'(dx_reg);
        my = dy_reg[33] ? 33'(-dy_reg) : 33'(dy_reg);
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        xs_reg      <= x_scale;
        ys_reg      <= y_scale;
        cols_reg    <= cols_c;
        rows_reg    <= rows_c;
        bad_cnt_reg <= (cols_c < LW'(2)) || (rows_c < LW'(2));
        px_reg      <= PW'(mx) * PW'(xs_reg);
        py_reg      <= PW'(my) * PW'(ys_reg);
        negx_reg    <= dx_reg[33];
        negy_reg    <= dy_reg[33];
        bad2_reg    <= bad_cnt_reg;
        cols2_reg   <= cols_reg;
        rows2_reg   <= rows_reg;
    end

    always_comb
    begin
        offx = px_reg >> FRAC_BITS;
        offy = py_reg >> FRAC_BITS;
        wx   = offx >> FRAC_BITS;
        wy   = offy >> FRAC_BITS;
        outx = (negx_reg && px_reg != '0) || (wx >= PW'(cols2_reg - LW'(1)));
        outy = (negy_reg && py_reg != '0) || (wy >= PW'(rows2_reg - LW'(1)));
    end

    always_ff @(posedge clk)
    begin
        q_ctrl.outside <= bad2_reg || outx || outy;
        q_ctrl.col_odd <= wx[0];
        q_ctrl.row_odd <= wy[0];
        q_col          <= wx[CW-1:0];
        q_row          <= wy[RW-1:0];
        q_fx           <= offx[FRAC_BITS-1:0];
        q_fy           <= offy[FRAC_BITS-1:0];
    end

endmodule

// ===== rtl/gbi_back.sv =====
module gbi_back
    import gbi_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = $clog2(MAX_ROWS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CW-1:0]        wr_col,
    input  logic [RW-1:0]        wr_row,
    input  logic signed [31:0]   wr_value,
    input  logic                 q_valid,
    input  gbi_ctrl_t            q_ctrl,
    input  logic [CW-1:0]        q_col,
    input  logic [RW-1:0]        q_row,
    input  logic [FRAC_BITS-1:0] q_fx,
    input  logic [FRAC_BITS-1:0] q_fy,
    output logic                 done,
    output logic signed [31:0]   interpolated_value,
    output logic [1:0]           status
);

    localparam int BC    = (MAX_COLS + 1) / 2;
    localparam int BR    = (MAX_ROWS + 1) / 2;
    localparam int BCW   = (BC > 1) ? $clog2(BC) : 1;
    localparam int BRW   = (BR > 1) ? $clog2(BR) : 1;
    localparam int BD    = 1 << (BCW + BRW);
    localparam int LWID  = 32 + FRAC_BITS + 3;
    localparam logic [LWID-1:0] HALF = LWID'(1) << (FRAC_BITS - 1);

    logic [BCW-1:0] c0, c1;
    logic [BRW-1:0] r0, r1;
    logic [31:0]    rd [4];

    // bank b = {row parity, col parity}
    always_comb
    begin
        c0 = BCW'((q_col + CW'(1)) >> 1);
        c1 = BCW'(q_col >> 1);
        r0 = BRW'((q_row + RW'(1)) >> 1);
        r1 = BRW'(q_row >> 1);
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [BCW-1:0] ra_c;
        logic [BRW-1:0] ra_r;
        logic           we_b;
        always_comb
        begin
            ra_c = ((b & 1) != 0) ? c1 : c0;
            ra_r = ((b & 2) != 0) ? r1 : r0;
            we_b = wr_en && (wr_col[0] == ((b & 1) != 0)) && (wr_row[0] == ((b & 2) != 0));
        end
        gbi_ram #(.WIDTH(32), .DEPTH(BD)) u_ram (
            .clk   (clk),
            .we    (we_b),
            .waddr ({BRW'(wr_row >> 1), BCW'(wr_col >> 1)}),
            .wdata (wr_value),
            .raddr ({ra_r, ra_c}),
            .rdata (rd[b])
        );
    end

    // stage a: memory read
    logic                 a_valid_reg;
    gbi_ctrl_t            a_ctrl_reg;
    logic [FRAC_BITS-1:0] a_fx_reg, a_fy_reg;
    logic signed [31:0]   tl, tr, bl, br;

    always_comb
    begin
        tl = rd[{a_ctrl_reg.row_odd, a_ctrl_reg.col_odd}];
        tr = rd[{a_ctrl_reg.row_odd, ~a_ctrl_reg.col_odd}];
        bl = rd[{~a_ctrl_reg.row_odd, a_ctrl_reg.col_odd}];
        br = rd[{~a_ctrl_reg.row_odd, ~a_ctrl_reg.col_odd}];
    end

    // stage b: row lerps
    logic                 b_valid_reg;
    logic [1:0]           b_st_reg;
    logic [FRAC_BITS-1:0] b_fy_reg;
    logic signed [31:0]   top_reg, bot_reg;

    function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [FRAC_BITS-1:0] f);
        logic signed [LWID-1:0] v;
        logic signed [LWID-1:0] s;
        begin
            v = LWID'(a) * $signed({1'b0, (LWID-1)'((LWID-1)'(1) << FRAC_BITS) - (LWID-1)'(f)})
              + LWID'(b) * $signed({1'b0, (LWID-1)'(f)});
            s = (v + $signed(HALF)) >>> FRAC_BITS;
            lerp = s[31:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done        <= 1'b0;
        end
        else
        begin
            a_valid_reg <= q_valid;
            b_valid_reg <= a_valid_reg;
            done        <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ctrl_reg <= q_ctrl;
        a_fx_reg   <= q_fx;
        a_fy_reg   <= q_fy;
        b_fy_reg   <= a_fy_reg;
        top_reg    <= lerp(tl, tr, a_fx_reg);
        bot_reg    <= lerp(bl, br, a_fx_reg);
        if (a_ctrl_reg.outside)
        begin
            b_st_reg <= ST_OUTSIDE;
        end
        else if (tl == 0 || tr == 0 || bl == 0 || br == 0)
        begin
            b_st_reg <= ST_NODATA;
        end
        else
        begin
            b_st_reg <= ST_OK;
        end
        status             <= b_st_reg;
        interpolated_value <= (b_st_reg == ST_OK) ? lerp(top_reg, bot_reg, b_fy_reg) : '0;
    end

endmodule

// ===== rtl/grid_bilinear_interpolator.sv =====
// done follows a query through s1_valid_reg, s2_valid_reg, q_valid, a_valid_reg and b_valid_reg into done
// a write passes through the wen_reg delay registers to reach the grid, behind any earlier query
// throughput: one word per cycle, writes and queries freely mixed; set by the
//   four parity banks that give all four neighbors in one read
// reset: rst_n clears the valid bits and loads the config defaults; grid contents undefined until written
// results carry a done strobe for one cycle; the receiver cannot stall
module grid_bilinear_interpolator
    import gbi_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [6:0]         cell_column,
    input  logic [6:0]         cell_row,
    input  logic signed [31:0] cell_value,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] interpolated_value,
    output logic [1:0]         status
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic signed [31:0] x_origin_reg, y_origin_reg;
    logic [31:0]        x_scale_reg, y_scale_reg;
    logic [7:0]         cols_reg, rows_reg;
    logic               mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            x_scale_reg  <= 32'd65536;
            y_scale_reg  <= 32'd65536;
            cols_reg     <= 8'd128;
            rows_reg     <= 8'd128;
            mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_ORIGIN: x_origin_reg <= cfg_data;
                REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                REG_X_SCALE:  x_scale_reg  <= cfg_data;
                REG_Y_SCALE:  y_scale_reg  <= cfg_data;
                REG_COLS:     cols_reg     <= cfg_data[7:0];
                REG_ROWS:     rows_reg     <= cfg_data[7:0];
                REG_MODE:     mode_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic wr_en;
    logic [13:0] wc, wr;
    always_comb
    begin
        wc    = 14'(cell_column);
        wr    = 14'(cell_row);
        wr_en = start && (opcode == OP_WRITE) && (wc < 14'(MAX_COLS)) && (wr < 14'(MAX_ROWS));
    end

    // writes trail the query pipeline so grid updates stay in word order
    logic [2:0]         wen_reg;
    logic [CW-1:0]      wcol_reg [3];
    logic [RW-1:0]      wrow_reg [3];
    logic signed [31:0] wval_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wen_reg <= '0;
        end
        else
        begin
            wen_reg <= {wen_reg[1:0], wr_en};
        end
    end

    always_ff @(posedge clk)
    begin
        wcol_reg[0] <= CW'(wc);
        wrow_reg[0] <= RW'(wr);
        wval_reg[0] <= cell_value;
        wcol_reg[1] <= wcol_reg[0];
        wrow_reg[1] <= wrow_reg[0];
        wval_reg[1] <= wval_reg[0];
        wcol_reg[2] <= wcol_reg[1];
        wrow_reg[2] <= wrow_reg[1];
        wval_reg[2] <= wval_reg[1];
    end

    logic                 q_valid;
    gbi_ctrl_t            q_ctrl;
    logic [CW-1:0]        q_col;
    logic [RW-1:0]        q_row;
    logic [FRAC_BITS-1:0] q_fx, q_fy;

    gbi_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && (opcode == OP_QUERY)),
        .query_x     (query_x),
        .query_y     (query_y),
        .x_origin    (x_origin_reg),
        .y_origin    (y_origin_reg),
        .x_scale     (x_scale_reg),
        .y_scale     (y_scale_reg),
        .cols_in_use (cols_reg),
        .rows_in_use (rows_reg),
        .depth_mode  (mode_reg),
        .q_valid     (q_valid),
        .q_ctrl      (q_ctrl),
        .q_col       (q_col),
        .q_row       (q_row),
        .q_fx        (q_fx),
        .q_fy        (q_fy)
    );

    gbi_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .wr_en              (wen_reg[2]),
        .wr_col             (wcol_reg[2]),
        .wr_row             (wrow_reg[2]),
        .wr_value           (wval_reg[2]),
        .q_valid            (q_valid),
        .q_ctrl             (q_ctrl),
        .q_col              (q_col),
        .q_row              (q_row),
        .q_fx               (q_fx),
        .q_fy               (q_fy),
        .done               (done),
        .interpolated_value (interpolated_value),
        .status             (status)
    );

endmodule
